// ----- sv/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants shared by the linear probe hash table block.
// ----------------------------------------------------------------------------
package lpht_pkg;

    // operation codes
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // per-slot state, code three is never written
    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_USED  = 2'd1,
        SLOT_TOMB  = 2'd2
    } t_slot_state;

    // configuration register indexes
    localparam logic [1:0] CFG_BUCKET_COUNT = 2'd0;
    localparam logic [1:0] CFG_LOAD_FACTOR  = 2'd1;

    localparam int BUCKET_W    = 11;
    localparam int LOAD_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int WORD_W      = 64;
    localparam int KEY_W       = 4 * WORD_W;
    localparam int COUNT_OUT_W = 11;
    localparam int PCT_SCALE   = 100;
    localparam int DIV_CNT_W   = $clog2(WORD_W);

    localparam logic [BUCKET_W-1:0] BUCKET_RESET = 11'd1024;
    localparam logic [LOAD_W-1:0]   LOAD_RESET   = 7'd70;

    typedef struct packed {
        t_op               operation;
        logic [WORD_W-1:0] key_word0;
        logic [WORD_W-1:0] key_word1;
        logic [WORD_W-1:0] key_word2;
        logic [WORD_W-1:0] key_word3;
        logic [WORD_W-1:0] value_in;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic [WORD_W-1:0]      value_out;
        logic [COUNT_OUT_W-1:0] entries_used;
        logic                   rehash_due;
    } t_out_item;

    // divider status towards the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // slot store write controls
    typedef struct packed {
        logic        st_we;
        logic        kv_we;
        t_slot_state st;
    } t_slot_wr;

endpackage

// ----- sv/lpht_divider.sv -----
// ----------------------------------------------------------------------------
// lpht_divider
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module lpht_divider
    import lpht_pkg::*;
#(
    parameter int DIV_W = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    output t_div_stat         o_stat,
    output logic [DIV_W-1:0]  o_remainder
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [WORD_W-1:0]    r_quo, n_quo;
    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_dvs, n_dvs;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 ge;

    // one compare and subtract step
    always_comb begin
        trial = {r_rem, r_quo[WORD_W-1]};
        ge    = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[WORD_W-2:0], ge};
            n_rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(WORD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_remainder = r_rem;

endmodule

// ----- sv/lpht_slot_store.sv -----
// ----------------------------------------------------------------------------
// lpht_slot_store
// Slot memories: state, key and value, one read and one write port each.
// ----------------------------------------------------------------------------
module lpht_slot_store
    import lpht_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic [AW-1:0]     i_wr_addr,
    input  t_slot_wr          i_wr,
    input  logic [KEY_W-1:0]  i_wr_key,
    input  logic [WORD_W-1:0] i_wr_value,
    output t_slot_state       o_rd_st,
    output logic [KEY_W-1:0]  o_rd_key,
    output logic [WORD_W-1:0] o_rd_value
);

    t_slot_state       st_mem  [DEPTH];
    logic [KEY_W-1:0]  key_mem [DEPTH];
    logic [WORD_W-1:0] val_mem [DEPTH];

    // slot state memory
    always_ff @(posedge i_clk) begin
        if (i_wr.st_we) begin
            st_mem[i_wr_addr] <= i_wr.st;
        end
        o_rd_st <= st_mem[i_rd_addr];
    end

    // key and value memories
    always_ff @(posedge i_clk) begin
        if (i_wr.kv_we) begin
            key_mem[i_wr_addr] <= i_wr_key;
            val_mem[i_wr_addr] <= i_wr_value;
        end
        o_rd_key   <= key_mem[i_rd_addr];
        o_rd_value <= val_mem[i_rd_addr];
    end

endmodule

// ----- sv/linear_probe_id_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// linear_probe_id_hash_table_unit
// Open addressing hash index on 256-bit keys with linear probing and
// tombstones.
// ----------------------------------------------------------------------------
// One item at a time. An item first finds its home slot (key_word0 modulo
// the slot count, one quotient bit per cycle in the divider), then probes
// slots through the registered slot memory read, a read state and an
// evaluate state per slot, then updates the table and, once the output
// register is free, loads it. A clear item sweeps the whole slot state memory,
// TABLE_DEPTH entries, then loads the result. After reset the block sweeps
// the slot state memory before the first item is taken. The load threshold
// is checked by a compare of scaled counts, so configuration writes need no
// division. The next item is accepted while a finished result still waits in
// the output register.
module linear_probe_id_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BUCKET_W-1:0]  i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = (NW > LOAD_W) ? NW : LOAD_W;
    localparam int TW = NW + LOAD_W;

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_HOME, S_RD, S_EVAL, S_FIN, S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [BUCKET_W-1:0] r_bucket_count;
    logic [LOAD_W-1:0]   r_lf;
    logic [NW-1:0]       r_count, n_count;
    t_in_item            r_item, n_item;
    logic [AW-1:0]       r_idx, n_idx;
    logic [NW-1:0]       r_steps, n_steps;
    logic                r_tomb_seen, n_tomb_seen;
    logic [AW-1:0]       r_tomb, n_tomb;
    logic                r_found, n_found;
    logic                r_has_free, n_has_free;
    logic [AW-1:0]       r_free, n_free;
    logic [WORD_W-1:0]   r_value, n_value;
    t_status             r_status, n_status;
    logic [AW-1:0]       r_sweep, n_sweep;
    logic                r_clr_pend, n_clr_pend;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic [NW-1:0]       slots;
    logic [NW-1:0]       steps_inc;
    logic [NW-1:0]       idx_inc;
    logic [TW:0]         thr_prod;
    logic [TW:0]         cnt_scaled;
    logic                div_start;
    logic [WORD_W-1:0]   div_dividend;
    logic [DW-1:0]       div_divisor;
    t_div_stat           div_stat;
    logic [DW-1:0]       div_rem;
    logic [AW-1:0]       wr_addr;
    t_slot_wr            wr;
    t_slot_state         rd_st;
    logic [KEY_W-1:0]    rd_key;
    logic [WORD_W-1:0]   rd_value;
    logic                key_hit;
    logic                out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_RESET;
            r_lf           <= LOAD_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_BUCKET_COUNT) begin
                r_bucket_count <= i_cfg_data;
            end else if (i_cfg_index == CFG_LOAD_FACTOR) begin
                r_lf <= i_cfg_data[LOAD_W-1:0];
            end
        end
    end

    // effective slot count
    always_comb begin
        if (r_bucket_count == '0 || 32'(r_bucket_count) > 32'(TABLE_DEPTH)) begin
            slots = NW'(TABLE_DEPTH);
        end else begin
            slots = NW'(r_bucket_count);
        end
    end

    // load threshold: count >= floor(slots * lf / 100) when
    // slots * lf < 100 * (count + 1)
    assign thr_prod   = (TW+1)'(slots) * (TW+1)'(r_lf);
    assign cnt_scaled = ((TW+1)'(r_count) + 1'b1) * (TW+1)'(PCT_SCALE);

    // home slot divider
    lpht_divider #(
        .DIV_W (DW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_stat      (div_stat),
        .o_remainder (div_rem)
    );

    // slot memories
    lpht_slot_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_addr  (r_idx),
        .i_wr_addr  (wr_addr),
        .i_wr       (wr),
        .i_wr_key   ({r_item.key_word3, r_item.key_word2,
                      r_item.key_word1, r_item.key_word0}),
        .i_wr_value (r_item.value_in),
        .o_rd_st    (rd_st),
        .o_rd_key   (rd_key),
        .o_rd_value (rd_value)
    );

    assign key_hit  = (rd_key == {r_item.key_word3, r_item.key_word2,
                                  r_item.key_word1, r_item.key_word0});
    assign steps_inc = r_steps + 1'b1;
    assign idx_inc   = NW'(r_idx) + 1'b1;
    assign out_free  = !r_out_valid || i_out_ready;

    // control sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_item       = r_item;
        n_idx        = r_idx;
        n_steps      = r_steps;
        n_tomb_seen  = r_tomb_seen;
        n_tomb       = r_tomb;
        n_found      = r_found;
        n_has_free   = r_has_free;
        n_free       = r_free;
        n_value      = r_value;
        n_status     = r_status;
        n_sweep      = r_sweep;
        n_clr_pend   = r_clr_pend;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        div_start    = 1'b0;
        div_dividend = i_in_item.key_word0;
        div_divisor  = DW'(slots);
        wr_addr      = r_sweep;
        wr.st_we     = 1'b0;
        wr.kv_we     = 1'b0;
        wr.st        = SLOT_EMPTY;
        o_in_ready   = 1'b0;

        case (r_state)
            S_SWEEP: begin
                wr.st_we = 1'b1;
                n_sweep  = r_sweep + 1'b1;
                if (r_sweep == AW'(TABLE_DEPTH - 1)) begin
                    n_sweep    = '0;
                    n_clr_pend = 1'b0;
                    n_state    = r_clr_pend ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item   = i_in_item;
                    n_status = ST_OK;
                    n_value  = '0;
                    if (i_in_item.operation == OP_CLEAR) begin
                        n_count    = '0;
                        n_clr_pend = 1'b1;
                        n_state    = S_SWEEP;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_HOME;
                    end
                end
            end
            S_HOME: begin
                if (div_stat.done) begin
                    n_idx       = div_rem[AW-1:0];
                    n_steps     = '0;
                    n_tomb_seen = 1'b0;
                    n_found     = 1'b0;
                    n_has_free  = 1'b0;
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_FIN;
                case (rd_st)
                    SLOT_EMPTY: begin
                        n_has_free = 1'b1;
                        n_free     = r_tomb_seen ? r_tomb : r_idx;
                    end
                    SLOT_USED: begin
                        if (key_hit) begin
                            n_found = 1'b1;
                            n_value = rd_value;
                        end
                    end
                    default: begin
                        if (!r_tomb_seen) begin
                            n_tomb_seen = 1'b1;
                            n_tomb      = r_idx;
                        end
                    end
                endcase
                // keep walking past used and tombstone slots
                if (rd_st != SLOT_EMPTY && !(rd_st == SLOT_USED && key_hit)) begin
                    n_steps = steps_inc;
                    if (steps_inc == slots) begin
                        n_has_free = n_tomb_seen;
                        n_free     = n_tomb;
                    end else begin
                        n_idx   = (idx_inc == slots) ? '0 : idx_inc[AW-1:0];
                        n_state = S_RD;
                    end
                end
            end
            S_FIN: begin
                n_state = S_OUT;
                case (r_item.operation)
                    OP_LOOKUP: begin
                        if (!r_found) begin
                            n_status = ST_NOT_FOUND;
                            n_value  = '0;
                        end
                    end
                    OP_INSERT: begin
                        n_value = '0;
                        if (r_found) begin
                            n_status = ST_DUPLICATE;
                        end else if (!r_has_free) begin
                            n_status = ST_FULL;
                        end else begin
                            wr_addr  = r_free;
                            wr.st_we = 1'b1;
                            wr.kv_we = 1'b1;
                            wr.st    = SLOT_USED;
                            n_count  = r_count + 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        n_value = '0;
                        if (r_found) begin
                            wr_addr  = r_idx;
                            wr.st_we = 1'b1;
                            wr.st    = SLOT_TOMB;
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_value = '0;
                    end
                endcase
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = r_status;
                    n_out.value_out    = r_value;
                    n_out.entries_used = COUNT_OUT_W'(r_count);
                    n_out.rehash_due   = (thr_prod < cnt_scaled);
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_count     <= '0;
            r_sweep     <= '0;
            r_clr_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sweep     <= n_sweep;
            r_clr_pend  <= n_clr_pend;
            r_out_valid <= n_out_valid;
        end
        r_item      <= n_item;
        r_idx       <= n_idx;
        r_steps     <= n_steps;
        r_tomb_seen <= n_tomb_seen;
        r_tomb      <= n_tomb;
        r_found     <= n_found;
        r_has_free  <= n_has_free;
        r_free      <= n_free;
        r_value     <= n_value;
        r_status    <= n_status;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- sv/lpht_checker.sv -----
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks on the hash table block, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker
    import lpht_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input t_in_item             i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_out_item            o_out_item,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [BUCKET_W-1:0]  i_cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // reset starts the slot sweep with nothing shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("block active right after reset");

    // only a successful lookup carries a value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.value_out == '0)
        else $error("failed item returned a value");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

endmodule

bind linear_probe_id_hash_table_unit lpht_checker u_lpht_checker (.*);

// ----- verif/linear_probe_id_hash_table_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_id_hash_table_unit_tb
// Self-checking bench for the linear probe hash index. A behavioural copy
// of the table predicts status, value, entry count and rehash flag for every
// accepted item; results are checked in order with random stalls both sides.
// ----------------------------------------------------------------------------
module linear_probe_id_hash_table_unit_tb;
    import lpht_pkg::*;

    localparam int DEPTH = 1024;

    // expected results, in order of acceptance
    class hash_scoreboard;
        t_out_item   pending[$];
        int          errors;
        t_slot_state st_mem[DEPTH];
        logic [KEY_W-1:0]  key_mem[DEPTH];
        logic [WORD_W-1:0] val_mem[DEPTH];
        int          live;
        int          buckets;
        int          load_pct;

        function void wipe();
            for (int i = 0; i < DEPTH; i++) st_mem[i] = SLOT_EMPTY;
            live = 0;
        endfunction

        function int span();
            if (buckets == 0 || buckets > DEPTH) return DEPTH;
            return buckets;
        endfunction

        // apply one accepted item to the table copy and queue its result
        function void note_item(t_in_item it);
            t_out_item r;
            logic [KEY_W-1:0] k;
            int n, idx, hit, tomb, free_s, thr;
            bit found, has_free;
            k = {it.key_word3, it.key_word2, it.key_word1, it.key_word0};
            n = span();
            r = '0;
            r.status = ST_OK;
            found = 0; has_free = 0; tomb = -1; hit = 0; free_s = 0;
            if (it.operation != OP_CLEAR) begin
                idx = int'(it.key_word0 % 64'(n));
                for (int i = 0; i < n; i++) begin
                    if (st_mem[idx] == SLOT_EMPTY) begin
                        has_free = 1;
                        free_s = (tomb >= 0) ? tomb : idx;
                        break;
                    end
                    if (st_mem[idx] == SLOT_USED) begin
                        if (key_mem[idx] == k) begin
                            found = 1; hit = idx;
                            break;
                        end
                    end else if (tomb < 0) begin
                        tomb = idx;
                    end
                    idx = (idx + 1 >= n) ? 0 : idx + 1;
                end
                if (!found && !has_free && tomb >= 0) begin
                    has_free = 1; free_s = tomb;
                end
            end
            case (it.operation)
                OP_CLEAR: wipe();
                OP_LOOKUP: begin
                    if (found) r.value_out = val_mem[hit];
                    else r.status = ST_NOT_FOUND;
                end
                OP_INSERT: begin
                    if (found) r.status = ST_DUPLICATE;
                    else if (!has_free) r.status = ST_FULL;
                    else begin
                        key_mem[free_s] = k;
                        val_mem[free_s] = it.value_in;
                        st_mem[free_s] = SLOT_USED;
                        live++;
                    end
                end
                default: begin
                    if (found) begin
                        st_mem[hit] = SLOT_TOMB;
                        if (live > 0) live--;
                    end else r.status = ST_NOT_FOUND;
                end
            endcase
            thr = (n * load_pct) / 100;
            r.entries_used = COUNT_OUT_W'(live);
            r.rehash_due = (live >= thr);
            pending.push_back(r);
        endfunction

        // compare one delivered result with the oldest expectation
        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %p", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.value_out !== e.value_out) begin
                $error("value_out exp %h got %h", e.value_out, got.value_out); errors++;
            end
            if (got.entries_used !== e.entries_used) begin
                $error("entries_used exp %0d got %0d", e.entries_used, got.entries_used);
                errors++;
            end
            if (got.rehash_due !== e.rehash_due) begin
                $error("rehash_due exp %0d got %0d", e.rehash_due, got.rehash_due);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_in_valid = 0;
    logic                 o_in_ready;
    t_in_item             i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 0;
    t_out_item            o_out_item;
    logic                 i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BUCKET_W-1:0]  i_cfg_data = '0;

    hash_scoreboard sb;
    bit  calm;
    int  results_seen;
    logic [WORD_W-1:0] recent_keys[$];

    always #1 i_clk = ~i_clk;

    linear_probe_id_hash_table_unit u_top (.*);

    // receiver: random stall bursts, checks each accepted result
    initial begin
        int hold;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_out_item);
                results_seen++;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 7);
                i_out_ready <= 0;
            end else i_out_ready <= 1;
        end
    end

    // send one item, with an optional idle burst first; valid is dropped
    // only by an idle burst or by the caller
    task automatic send_item(t_in_item it);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
    endtask

    task automatic send_op(t_op op, logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                           logic [WORD_W-1:0] val);
        t_in_item it;
        it.operation = op;
        it.key_word0 = w0;
        it.key_word1 = w1;
        it.key_word2 = ~w1;
        it.key_word3 = w0 ^ 64'h5a5a_0000_ffff_1234;
        it.value_in  = val;
        send_item(it);
    endtask

    // wait for the queue to drain, then write a register while idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= BUCKET_W'(data);
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_BUCKET_COUNT) sb.buckets = data;
        else sb.load_pct = data & 7'h7f;
    endtask

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random phase: mostly well-formed traffic on a small key pool
    task automatic random_phase(int count, int pool);
        logic [WORD_W-1:0] w0;
        t_in_item it;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_op(OP_CLEAR, rand64(), rand64(), rand64());
                recent_keys.delete();
                continue;
            end
            if (r < 8) begin
                it = {2'(r % 3), $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom};
                send_item(it);
                continue;
            end
            if (recent_keys.size() > 0 && $urandom_range(0, 1))
                w0 = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            else begin
                w0 = {$urandom, 32'($urandom_range(0, pool))};
                if ($urandom_range(0, 3) == 0) w0 = rand64();
                recent_keys.push_back(w0);
                if (recent_keys.size() > 64) void'(recent_keys.pop_front());
            end
            r = $urandom_range(0, 9);
            send_op(r < 5 ? OP_INSERT : (r < 8 ? OP_LOOKUP : OP_DELETE),
                    w0, w0 * 3, rand64());
        end
    endtask

    initial begin
        sb = new();
        sb.buckets = 1024;
        sb.load_pct = 70;
        sb.wipe();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, duplicates, tombstones, full table, clear
        send_op(OP_LOOKUP, 64'd0, 64'd0, 64'd0);
        send_op(OP_INSERT, 64'd0, 64'd0, '1);
        send_op(OP_INSERT, 64'd0, 64'd0, 64'd7);
        send_op(OP_LOOKUP, 64'd0, 64'd0, 64'd0);
        send_op(OP_INSERT, '1, '1, 64'hdead_beef_0123_4567);
        send_op(OP_INSERT, 64'd1024, 64'd5, 64'd9);
        send_op(OP_DELETE, 64'd0, 64'd0, 64'd0);
        send_op(OP_LOOKUP, 64'd1024, 64'd5, 64'd0);
        send_op(OP_INSERT, 64'd2048, 64'd1, 64'd3);
        send_op(OP_DELETE, 64'd77, 64'd1, 64'd0);
        send_op(OP_CLEAR, '1, '1, '1);
        write_reg(CFG_BUCKET_COUNT, 2);
        write_reg(CFG_LOAD_FACTOR, 100);
        send_op(OP_INSERT, 64'd4, 64'd1, 64'd11);
        send_op(OP_INSERT, 64'd5, 64'd1, 64'd12);
        send_op(OP_INSERT, 64'd6, 64'd1, 64'd13);
        send_op(OP_DELETE, 64'd4, 64'd1, 64'd0);
        send_op(OP_LOOKUP, 64'd6, 64'd1, 64'd0);
        send_op(OP_INSERT, 64'd6, 64'd1, 64'd14);
        send_op(OP_DELETE, 64'd5, 64'd1, 64'd0);
        send_op(OP_LOOKUP, 64'd9, 64'd1, 64'd0);
        write_reg(CFG_BUCKET_COUNT, 0);
        write_reg(CFG_LOAD_FACTOR, 0);
        send_op(OP_LOOKUP, 64'd5, 64'd1, 64'd0);
        send_op(OP_CLEAR, 64'd0, 64'd0, 64'd0);

        // random phases across several settings
        write_reg(CFG_BUCKET_COUNT, 1);
        write_reg(CFG_LOAD_FACTOR, 1);
        random_phase(120, 4);
        write_reg(CFG_BUCKET_COUNT, 13);
        write_reg(CFG_LOAD_FACTOR, 50);
        random_phase(350, 40);
        write_reg(CFG_BUCKET_COUNT, 2047);
        write_reg(CFG_LOAD_FACTOR, 127);
        random_phase(200, 3000);
        write_reg(CFG_BUCKET_COUNT, 8);
        write_reg(CFG_LOAD_FACTOR, 70);
        random_phase(350, 30);
        write_reg(CFG_BUCKET_COUNT, 1024);
        write_reg(CFG_LOAD_FACTOR, 100);
        random_phase(250, 5000);
        calm = 1;
        write_reg(CFG_BUCKET_COUNT, 5);
        random_phase(200, 20);

        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("covered %0d results over bucket counts 1 to 2047 with stalls",
                 results_seen);
        if (sb.errors == 0)
            $display("linear_probe_id_hash_table_unit: match");
        else
            $display("linear_probe_id_hash_table_unit: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("linear_probe_id_hash_table_unit: mismatch");
        $finish;
    end

endmodule
